>>> src/patb_pkg.sv
package patb_pkg;

  localparam int unsigned SlotsDefault    = 16;
  localparam int unsigned TimeBitsDefault = 24;

  localparam int unsigned KindW  = 3;
  localparam int unsigned StepW  = 16;
  localparam int unsigned StampW = 32;
  localparam int unsigned GroupW = 8;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned FieldW = 24;
  localparam int unsigned EventW = 3;

  localparam logic [KindW-1:0] KindTick      = 3'd0;
  localparam logic [KindW-1:0] KindStart     = 3'd1;
  localparam logic [KindW-1:0] KindCancelGrp = 3'd2;
  localparam logic [KindW-1:0] KindCancelOne = 3'd3;
  localparam logic [KindW-1:0] KindCancelAll = 3'd4;
  localparam logic [KindW-1:0] KindNop       = 3'd7;

  localparam logic [EventW-1:0] EvNone      = 3'd0;
  localparam logic [EventW-1:0] EvStarted   = 3'd1;
  localparam logic [EventW-1:0] EvFull      = 3'd2;
  localparam logic [EventW-1:0] EvTick      = 3'd3;
  localparam logic [EventW-1:0] EvAlarm     = 3'd4;
  localparam logic [EventW-1:0] EvCancelled = 3'd5;

  localparam logic [1:0] ReactContinue = 2'd0;
  localparam logic [1:0] ReactStop     = 2'd1;
  localparam logic [1:0] ReactStopTick = 2'd2;
  localparam logic [1:0] ReactRestart  = 2'd3;

  // One classified command, handed from the front end to the sweep engine.
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StepW-1:0]  step;
    logic [GroupW-1:0] group;
    logic [SlotW-1:0]  slot;
    logic [FieldW-1:0] tick_period;
    logic [FieldW-1:0] alarm_period;
    logic              tick_enable;
    logic              alarm_enable;
    logic [1:0]        tick_reaction;
    logic              alarm_restart;
  } cmd_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [SlotW-1:0]  event_slot;
    logic [FieldW-1:0] elapsed_alarm;
    logic [FieldW-1:0] alarm_length;
    logic              last;
  } res_t;

endpackage

>>> src/patb_front.sv
module patb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [patb_pkg::KindW-1:0]  kind_i,
  input  logic [patb_pkg::StampW-1:0] stamp_i,
  input  patb_pkg::cmd_t              cmd_i,
  input  logic                        any_live_i,
  output logic                        q_valid_o,
  output patb_pkg::cmd_t              q_cmd_o,
  input  logic                        q_take_i
);

  // Two-entry queue between the front end and the sweep engine.
  patb_pkg::cmd_t mem_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [patb_pkg::StampW-1:0] stamp_q, stamp_d;
  logic           seen_q, seen_d;
  logic           acc, ign;
  patb_pkg::cmd_t cmd_w;

  assign full_o    = (cnt_q == 2'd2);
  assign acc       = push_i && !full_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = mem_q[rd_q];

  // The stamp filter only sees live state while the queue is empty, so ticks
  // stall until the engine has drained everything ahead of them.
  always_comb begin
    ign     = 1'b0;
    stamp_d = stamp_q;
    seen_d  = seen_q;
    if (acc && kind_i == patb_pkg::KindTick) begin
      if (!any_live_i || (seen_q && stamp_i == stamp_q)) begin
        ign = 1'b1;
      end else begin
        stamp_d = stamp_i;
        seen_d  = 1'b1;
      end
    end
  end

  // A tick that must be ignored is queued as an unknown kind.
  always_comb begin
    cmd_w = cmd_i;
    if (ign) cmd_w.kind = patb_pkg::KindNop;
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (acc) wr_d = ~wr_q;
    if (q_take_i) rd_d = ~rd_q;
    cnt_d = cnt_q + {1'b0, acc} - {1'b0, q_take_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= 2'd0;
      stamp_q <= '0;
      seen_q  <= 1'b0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      cnt_q   <= cnt_d;
      stamp_q <= stamp_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem_q[wr_q] <= cmd_w;
    end
  end

endmodule

>>> src/patb_engine.sv
module patb_engine #(
  parameter int unsigned SLOTS     = patb_pkg::SlotsDefault,
  parameter int unsigned TIME_BITS = patb_pkg::TimeBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  patb_pkg::cmd_t q_cmd_i,
  output logic           q_take_o,
  output logic           idle_o,
  output logic           any_live_o,
  output logic           res_valid_o,
  output patb_pkg::res_t res_o,
  input  logic           res_take_i
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned CntW = (TIME_BITS > patb_pkg::StepW) ? TIME_BITS : patb_pkg::StepW;
  localparam int unsigned LW   = CntW + 1;
  localparam int unsigned CW   = (TIME_BITS < patb_pkg::FieldW) ? TIME_BITS : patb_pkg::FieldW;
  localparam logic signed [LW:0] ECap = (LW+1)'({CW{1'b1}});

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSweep = 2'd1;
  localparam logic [1:0] StAlarm = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [SLOTS-1:0] live_q, ton_q, aon_q, arm_q;
  logic signed [LW-1:0] tleft_q [SLOTS];
  logic signed [LW-1:0] aleft_q [SLOTS];
  logic [TIME_BITS-1:0] trel_q [SLOTS];
  logic [TIME_BITS-1:0] arel_q [SLOTS];
  logic [patb_pkg::GroupW-1:0] grp_q [SLOTS];
  logic [1:0] tact_q [SLOTS];
  logic       aact_q [SLOTS];

  logic [1:0]    st_q;
  logic [IW-1:0] idx_q;
  patb_pkg::cmd_t cmd_q;
  logic          pend_q;     // result register holds an unsent item
  patb_pkg::res_t out_q;
  // The latest sweep event is held back until it is known whether it is the final one.
  logic          hold_v_q;
  patb_pkg::res_t hold_q;

  assign any_live_o  = |live_q;
  assign idle_o      = (st_q == StIdle) && !pend_q;
  assign res_valid_o = pend_q;
  assign res_o       = out_q;

  logic free_out;
  assign free_out = !pend_q || res_take_i;

  // Lowest free slot.
  logic [IW-1:0] fidx;
  logic          fok;
  always_comb begin
    fidx = '0;
    fok  = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!live_q[k]) begin
        fidx = IW'(k);
        fok  = 1'b1;
      end
    end
  end

  logic signed [LW-1:0] step_s, tnew, anew;
  logic [IW-1:0] ix;
  assign ix     = idx_q;
  assign step_s = LW'(cmd_q.step);
  assign tnew   = tleft_q[ix] - step_s;
  assign anew   = aleft_q[ix] - step_s;

  logic signed [LW:0] ediff, adiff;
  logic [patb_pkg::FieldW-1:0] elap, aelap;
  always_comb begin
    ediff = $signed((LW+1)'(arel_q[ix])) - (LW+1)'(aleft_q[ix]);
    if (!aon_q[ix] || ediff[LW]) elap = '0;
    else elap = patb_pkg::FieldW'(ediff[TIME_BITS-1:0]);
  end

  // Elapsed alarm time after this step, clamped to the output range.
  always_comb begin
    adiff = $signed((LW+1)'(arel_q[ix])) - (LW+1)'(anew);
    if (adiff[LW]) aelap = '0;
    else if (adiff > ECap) aelap = patb_pkg::FieldW'({CW{1'b1}});
    else aelap = patb_pkg::FieldW'(adiff[CW-1:0]);
  end

  logic last_ix;
  assign last_ix = (idx_q == IW'(SLOTS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      ton_q     <= '0;
      aon_q     <= '0;
      arm_q     <= '0;
      st_q      <= StIdle;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      hold_v_q  <= 1'b0;
    end else begin
      if (res_take_i) pend_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (q_valid_i && free_out) begin
            cmd_q     <= q_cmd_i;
            idx_q     <= '0;
            case (q_cmd_i.kind)
              patb_pkg::KindStart: begin
                pend_q <= 1'b1;
                if (fok) begin
                  live_q[fidx] <= 1'b1;
                  grp_q[fidx]  <= q_cmd_i.group;
                  trel_q[fidx] <= TIME_BITS'(q_cmd_i.tick_period);
                  arel_q[fidx] <= TIME_BITS'(q_cmd_i.alarm_period);
                  tleft_q[fidx] <= LW'(TIME_BITS'(q_cmd_i.tick_period));
                  aleft_q[fidx] <= LW'(TIME_BITS'(q_cmd_i.alarm_period));
                  arm_q[fidx]  <= q_cmd_i.tick_enable;
                  ton_q[fidx]  <= q_cmd_i.tick_enable;
                  aon_q[fidx]  <= q_cmd_i.alarm_enable;
                  tact_q[fidx] <= q_cmd_i.tick_reaction;
                  aact_q[fidx] <= q_cmd_i.alarm_restart;
                  out_q <= '{patb_pkg::EvStarted, patb_pkg::SlotW'(fidx), '0, '0, 1'b1};
                end else begin
                  out_q <= '{patb_pkg::EvFull, '0, '0, '0, 1'b1};
                end
              end
              patb_pkg::KindCancelOne: begin
                pend_q <= 1'b1;
                if (32'(q_cmd_i.slot) < SLOTS && live_q[IW'(q_cmd_i.slot)]) begin
                  live_q[IW'(q_cmd_i.slot)] <= 1'b0;
                  ton_q[IW'(q_cmd_i.slot)]  <= 1'b0;
                  aon_q[IW'(q_cmd_i.slot)]  <= 1'b0;
                  out_q <= '{patb_pkg::EvCancelled, q_cmd_i.slot, '0, '0, 1'b1};
                end else begin
                  out_q <= '{patb_pkg::EvNone, '0, '0, '0, 1'b1};
                end
              end
              patb_pkg::KindTick, patb_pkg::KindCancelGrp,
              patb_pkg::KindCancelAll: st_q <= StSweep;
              default: begin
                pend_q <= 1'b1;
                out_q  <= '{patb_pkg::EvNone, '0, '0, '0, 1'b1};
              end
            endcase
          end
        end
        StSweep: begin
          if (free_out) begin
            if (cmd_q.kind != patb_pkg::KindTick) begin
              if (live_q[ix] && (cmd_q.kind == patb_pkg::KindCancelAll ||
                                 grp_q[ix] == cmd_q.group)) begin
                live_q[ix] <= 1'b0;
                ton_q[ix]  <= 1'b0;
                aon_q[ix]  <= 1'b0;
                if (hold_v_q) begin
                  pend_q <= 1'b1;
                  out_q  <= hold_q;
                end
                hold_q   <= '{patb_pkg::EvCancelled, patb_pkg::SlotW'(ix), '0, '0, 1'b0};
                hold_v_q <= 1'b1;
              end
              if (last_ix) st_q <= StFlush;
              idx_q <= idx_q + 1'b1;
            end else if (live_q[ix] && ton_q[ix]) begin
              st_q <= StAlarm;
              if (tnew <= 0) begin
                if (hold_v_q) begin
                  pend_q <= 1'b1;
                  out_q  <= hold_q;
                end
                hold_q <= '{patb_pkg::EvTick, patb_pkg::SlotW'(ix), elap,
                            patb_pkg::FieldW'(arel_q[ix]), 1'b0};
                hold_v_q <= 1'b1;
                case (tact_q[ix])
                  patb_pkg::ReactContinue: tleft_q[ix] <= LW'(trel_q[ix]);
                  patb_pkg::ReactStop: begin
                    tleft_q[ix] <= tnew;
                    live_q[ix]  <= 1'b0;
                    ton_q[ix]   <= 1'b0;
                    aon_q[ix]   <= 1'b0;
                  end
                  patb_pkg::ReactStopTick: begin
                    tleft_q[ix] <= tnew;
                    ton_q[ix]   <= 1'b0;
                  end
                  default: begin
                    tleft_q[ix] <= LW'(trel_q[ix]);
                    aleft_q[ix] <= LW'(arel_q[ix]);
                    ton_q[ix]   <= arm_q[ix];
                  end
                endcase
              end else begin
                tleft_q[ix] <= tnew;
              end
            end else begin
              st_q <= StAlarm;
            end
          end
        end
        StFlush: begin
          if (free_out) begin
            pend_q   <= 1'b1;
            out_q    <= hold_v_q ? '{hold_q.event_res, hold_q.event_slot,
                                     hold_q.elapsed_alarm, hold_q.alarm_length, 1'b1}
                                 : '{patb_pkg::EvNone, '0, '0, '0, 1'b1};
            hold_v_q <= 1'b0;
            st_q     <= StIdle;
          end
        end
        default: begin // StAlarm
          if (free_out) begin
            if (live_q[ix] && aon_q[ix]) begin
              if (anew <= 0) begin
                if (hold_v_q) begin
                  pend_q <= 1'b1;
                  out_q  <= hold_q;
                end
                hold_q <= '{patb_pkg::EvAlarm, patb_pkg::SlotW'(ix), aelap,
                            patb_pkg::FieldW'(arel_q[ix]), 1'b0};
                hold_v_q <= 1'b1;
                if (aact_q[ix]) begin
                  tleft_q[ix] <= LW'(trel_q[ix]);
                  aleft_q[ix] <= LW'(arel_q[ix]);
                  ton_q[ix]   <= arm_q[ix];
                end else begin
                  aleft_q[ix] <= anew;
                  live_q[ix]  <= 1'b0;
                  ton_q[ix]   <= 1'b0;
                  aon_q[ix]   <= 1'b0;
                end
              end else begin
                aleft_q[ix] <= anew;
              end
            end
            idx_q <= idx_q + 1'b1;
            st_q  <= last_ix ? StFlush : StSweep;
          end
        end
      endcase
    end
  end

  assign q_take_o = (st_q == StIdle) && q_valid_i && free_out;

endmodule

>>> src/periodic_alarm_timer_bank_top.sv
// Bank of timer slots with periodic ticks and one-shot alarms.
// Items enter through push/full; results leave through empty/pop,
// the oldest result on the result ports while empty is low.
// A start, cancel-slot or unknown item gives one result, set up when the engine
// takes the item from the queue. Tick, cancel-group and cancel-all items sweep
// the slots: a tick visits each slot in a tick state and then an alarm state,
// a cancel visits each slot once, and a closing flush state ends the sweep; a
// sweep waits whenever the result register holds an unpopped result.
// Each slot may emit a tick and an alarm; a sweep event leaves the engine
// when the next one is found or when the sweep closes.
// The final result of an item has last_o set; an item causing no event gives
// one result with event_res_o zero.
// A two-entry queue sits between the input front end and the sweep engine.
// A tick is only taken once the queue is empty, the engine is idle and no
// result is waiting, so items are handled one after another.
// When pop is held low the engine waits on its result register and the
// queue fills, after which full rises.
// Reset frees every slot and forgets the last tick stamp; no clearing pass.
module periodic_alarm_timer_bank_top #(
  parameter int unsigned SLOTS     = patb_pkg::SlotsDefault,
  parameter int unsigned TIME_BITS = patb_pkg::TimeBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind_i,
  input  logic [15:0] elapsed_step_i,
  input  logic [31:0] stamp_i,
  input  logic [7:0]  group_i,
  input  logic [3:0]  slot_i,
  input  logic [23:0] tick_period_i,
  input  logic [23:0] alarm_period_i,
  input  logic        tick_enable_i,
  input  logic        alarm_enable_i,
  input  logic [1:0]  tick_reaction_i,
  input  logic        alarm_restart_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res_o,
  output logic [3:0]  event_slot_o,
  output logic [23:0] elapsed_alarm_o,
  output logic [23:0] alarm_length_o,
  output logic        last_o
);

  patb_pkg::cmd_t cmd_in, q_cmd;
  patb_pkg::res_t res;
  logic q_valid, q_take, idle, any_live, res_valid, fe_full;

  assign cmd_in = '{kind_i, elapsed_step_i, group_i, slot_i, tick_period_i,
                    alarm_period_i, tick_enable_i, alarm_enable_i,
                    tick_reaction_i, alarm_restart_i};

  // Ticks wait until the engine is idle so that the live view is current.
  logic tick_block;
  assign tick_block = (kind_i == patb_pkg::KindTick) && (q_valid || !idle);
  assign full = fe_full || tick_block;

  patb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push && !tick_block),
    .full_o     (fe_full),
    .kind_i     (kind_i),
    .stamp_i    (stamp_i),
    .cmd_i      (cmd_in),
    .any_live_i (any_live),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .q_take_i   (q_take)
  );

  patb_engine #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_take_o    (q_take),
    .idle_o      (idle),
    .any_live_o  (any_live),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (pop && res_valid)
  );

  assign empty           = !res_valid;
  assign event_res_o     = res.event_res;
  assign event_slot_o    = res.event_slot;
  assign elapsed_alarm_o = res.elapsed_alarm;
  assign alarm_length_o  = res.alarm_length;
  assign last_o          = res.last;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NumSlots  = 16;
  localparam int Idle      = 4000;
  localparam int DrainWait = 80;

  typedef struct {
    logic [2:0]  ev;
    logic [3:0]  slot;
    logic [23:0] elapsed;
    logic [23:0] length;
    logic        last;
  } event_t;

  // Scoreboard: holds its own copy of the timer bank and the queue of events it owes.
  class timer_scoreboard;
    bit          live[NumSlots];
    bit          tick_run[NumSlots];
    bit          alarm_run[NumSlots];
    bit          tick_arm[NumSlots];
    longint      tick_rem[NumSlots];
    longint      alarm_rem[NumSlots];
    logic [23:0] tick_per[NumSlots];
    logic [23:0] alarm_per[NumSlots];
    logic [7:0]  grp[NumSlots];
    logic [1:0]  react[NumSlots];
    bit          restart[NumSlots];
    logic [31:0] prev_stamp;
    bit          stamp_valid;
    event_t      pending[$];
    int          mismatches;

    function void post(logic [2:0] ev, int s, bit with_times);
      event_t e;
      longint d;
      e.ev = ev;
      e.slot = s[3:0];
      e.elapsed = '0;
      e.length = '0;
      e.last = 1'b0;
      if (with_times) begin
        e.length = alarm_per[s];
        if (alarm_run[s]) begin
          d = longint'(alarm_per[s]) - alarm_rem[s];
          if (d < 0) d = 0;
          if (d > 24'hFFFFFF) d = 24'hFFFFFF;
          e.elapsed = d[23:0];
        end
      end
      pending = {pending, e};
    endfunction

    function void release_slot(int s);
      live[s] = 0;
      tick_run[s] = 0;
      alarm_run[s] = 0;
    endfunction

    function void rearm(int s);
      tick_rem[s] = longint'(tick_per[s]);
      alarm_rem[s] = longint'(alarm_per[s]);
      tick_run[s] = tick_arm[s];
    endfunction

    function int sweep(logic [15:0] step, logic [31:0] stamp);
      int n;
      bit any;
      n = 0;
      any = 0;
      foreach (live[i]) if (live[i]) any = 1;
      if (!any || (stamp_valid && stamp == prev_stamp)) return 0;
      prev_stamp = stamp;
      stamp_valid = 1;
      for (int i = 0; i < NumSlots; i++) begin
        if (!live[i]) continue;
        if (tick_run[i]) begin
          tick_rem[i] -= longint'(step);
          if (tick_rem[i] <= 0) begin
            post(patb_pkg::EvTick, i, 1);
            n++;
            case (react[i])
              patb_pkg::ReactContinue: tick_rem[i] = longint'(tick_per[i]);
              patb_pkg::ReactStop:     release_slot(i);
              patb_pkg::ReactStopTick: tick_run[i] = 0;
              default:                 rearm(i);
            endcase
            if (!live[i]) continue;
          end
        end
        if (alarm_run[i]) begin
          alarm_rem[i] -= longint'(step);
          if (alarm_rem[i] <= 0) begin
            post(patb_pkg::EvAlarm, i, 1);
            n++;
            if (restart[i]) rearm(i);
            else release_slot(i);
          end
        end
      end
      return n;
    endfunction

    function void note_input(logic [2:0] kind, logic [15:0] step, logic [31:0] stamp,
                             logic [7:0] g, logic [3:0] sl, logic [23:0] tp,
                             logic [23:0] ap, bit te, bit ae, logic [1:0] tr, bit ar);
      int n;
      int s;
      n = 0;
      s = 0;
      case (kind)
        patb_pkg::KindTick: n = sweep(step, stamp);
        patb_pkg::KindStart: begin
          while (s < NumSlots && live[s]) s++;
          if (s < NumSlots) begin
            live[s] = 1;
            grp[s] = g;
            tick_per[s] = tp;
            alarm_per[s] = ap;
            tick_arm[s] = te;
            tick_run[s] = te;
            alarm_run[s] = ae;
            react[s] = tr;
            restart[s] = ar;
            tick_rem[s] = longint'(tp);
            alarm_rem[s] = longint'(ap);
            post(patb_pkg::EvStarted, s, 0);
          end else begin
            post(patb_pkg::EvFull, 0, 0);
          end
          n = 1;
        end
        patb_pkg::KindCancelGrp, patb_pkg::KindCancelAll: begin
          for (int i = 0; i < NumSlots; i++)
            if (live[i] && (kind == patb_pkg::KindCancelAll || grp[i] == g)) begin
              release_slot(i);
              post(patb_pkg::EvCancelled, i, 0);
              n++;
            end
        end
        patb_pkg::KindCancelOne: begin
          if (live[sl]) begin
            release_slot(int'(sl));
            post(patb_pkg::EvCancelled, int'(sl), 0);
            n = 1;
          end
        end
        default: ;
      endcase
      if (n == 0) post(patb_pkg::EvNone, 0, 0);
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [2:0] ev, logic [3:0] sl, logic [23:0] ea,
                               logic [23:0] al, logic lst);
      event_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: exp none, got ev=%0d slot=%0d ea=%0d al=%0d last=%0d",
                   ev, sl, ea, al, lst);
        return;
      end
      e = pending.pop_front();
      if (ev !== e.ev || sl !== e.slot || ea !== e.elapsed || al !== e.length ||
          lst !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp ev=%0d slot=%0d ea=%0d al=%0d last=%0d, got %0d %0d %0d %0d %0d",
                   e.ev, e.slot, e.elapsed, e.length, e.last, ev, sl, ea, al, lst);
      end
    endfunction
  endclass

  logic clk_i, rst_ni, push, full, empty, pop;
  logic [2:0]  kind_i;
  logic [15:0] elapsed_step_i;
  logic [31:0] stamp_i;
  logic [7:0]  group_i;
  logic [3:0]  slot_i;
  logic [23:0] tick_period_i, alarm_period_i;
  logic        tick_enable_i, alarm_enable_i, alarm_restart_i;
  logic [1:0]  tick_reaction_i;
  logic [2:0]  event_res_o;
  logic [3:0]  event_slot_o;
  logic [23:0] elapsed_alarm_o, alarm_length_o;
  logic        last_o;

  periodic_alarm_timer_bank_top dut (.*);

  timer_scoreboard sb = new();
  bit   feeding_done;
  int   quiet_cycles = 0;
  logic [31:0] stamp_ctr;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    push = 0;
    pop = 0;
    kind_i = '0;
    elapsed_step_i = '0;
    stamp_i = '0;
    group_i = '0;
    slot_i = '0;
    tick_period_i = '0;
    alarm_period_i = '0;
    tick_enable_i = 0;
    alarm_enable_i = 0;
    tick_reaction_i = '0;
    alarm_restart_i = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
  end

  task automatic send(logic [2:0] k, logic [15:0] st, logic [31:0] sp, logic [7:0] g,
                      logic [3:0] sl, logic [23:0] tp, logic [23:0] ap, bit te, bit ae,
                      logic [1:0] tr, bit ar);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1;
    kind_i <= k;
    elapsed_step_i <= st;
    stamp_i <= sp;
    group_i <= g;
    slot_i <= sl;
    tick_period_i <= tp;
    alarm_period_i <= ap;
    tick_enable_i <= te;
    alarm_enable_i <= ae;
    tick_reaction_i <= tr;
    alarm_restart_i <= ar;
    do @(posedge clk_i); while (full);
    sb.note_input(k, st, sp, g, sl, tp, ap, te, ae, tr, ar);
  endtask

  task automatic tick(logic [15:0] st);
    stamp_ctr++;
    send(patb_pkg::KindTick, st, stamp_ctr, '0, '0, '0, '0, 0, 0, '0, 0);
  endtask

  task automatic start(logic [7:0] g, logic [23:0] tp, logic [23:0] ap, bit te, bit ae,
                       logic [1:0] tr, bit ar);
    send(patb_pkg::KindStart, '0, '0, g, '0, tp, ap, te, ae, tr, ar);
  endtask

  task automatic send_random;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // Mostly short steps against short periods so counters expire often.
      if ($urandom_range(0, 9) == 0)
        send(patb_pkg::KindTick, 16'($urandom), stamp_ctr, '0, '0, '0, '0, 0, 0, '0, 0);
      else tick(16'($urandom_range(0, 40)));
    end else if (r < 75) begin
      start(8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
            24'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 120)),
            24'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 200)),
            1'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
    end else if (r < 85) begin
      send(patb_pkg::KindCancelOne, '0, '0, '0, 4'($urandom), '0, '0, 0, 0, '0, 0);
    end else if (r < 93) begin
      send(patb_pkg::KindCancelGrp, '0, '0, 8'($urandom_range(0, 3)), '0, '0, '0, 0, 0,
           '0, 0);
    end else if (r < 96) begin
      send(patb_pkg::KindCancelAll, '0, '0, '0, '0, '0, '0, 0, 0, '0, 0);
    end else begin
      send(3'($urandom_range(5, 7)), 16'($urandom), $urandom, 8'($urandom), 4'($urandom),
           24'($urandom), 24'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
           1'($urandom));
    end
  endtask

  initial begin
    feeding_done = 0;
    stamp_ctr = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    // Idle tick with no live slot, then a start of every reaction.
    tick(16'd5);
    start(8'hFF, 24'hFFFFFF, 24'hFFFFFF, 1, 1, patb_pkg::ReactContinue, 1);
    start(8'h00, 24'd0, 24'd0, 1, 1, patb_pkg::ReactStop, 0);
    start(8'h01, 24'd3, 24'd10, 1, 1, patb_pkg::ReactStopTick, 0);
    start(8'h01, 24'd2, 24'd5, 1, 1, patb_pkg::ReactRestart, 1);
    start(8'h02, 24'd4, 24'd0, 1, 0, patb_pkg::ReactContinue, 0);
    send(patb_pkg::KindTick, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, '0, '0, 0, 0, '0, 0);
    // Same stamp again is ignored.
    send(patb_pkg::KindTick, 16'h0001, 32'hFFFF_FFFF, '0, '0, '0, '0, 0, 0, '0, 0);
    tick(16'd0);
    for (int i = 0; i < 17; i++) start(8'(i), 24'd100, 24'd100, i[0], i[1], i[3:2], i[0]);
    send(patb_pkg::KindCancelOne, '0, '0, '0, 4'hF, '0, '0, 0, 0, '0, 0);
    send(patb_pkg::KindCancelOne, '0, '0, '0, 4'hF, '0, '0, 0, 0, '0, 0);
    send(patb_pkg::KindCancelGrp, '0, '0, 8'h01, '0, '0, '0, 0, 0, '0, 0);
    send(patb_pkg::KindCancelAll, '0, '0, '0, '0, '0, '0, 0, 0, '0, 0);
    send(patb_pkg::KindNop, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 24'hFFFFFF, 24'hFFFFFF,
         1, 1, patb_pkg::ReactRestart, 1);
    for (int n = 0; n < 340; n++) send_random();
    push <= 0;
    feeding_done = 1;
  end

  initial begin
    int wait_pop;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) continue;
      if (pop && !empty) begin
        sb.check_result(event_res_o, event_slot_o, elapsed_alarm_o, alarm_length_o, last_o);
        wait_pop = $urandom_range(0, 6);
        if (wait_pop > 0) begin
          pop <= 0;
          repeat (wait_pop) @(posedge clk_i);
        end
        pop <= 1;
      end else if (!pop) begin
        pop <= 1;
      end
    end
  end

  // A transfer on either side resets the watchdog.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= Idle) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    wait (feeding_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
